[src/sacache_pkg.sv]
// Shared types and constants of the set-associative cache tag and replacement unit.
`default_nettype none

package sacache_pkg;

    // Fixed field widths
    localparam int ADDR_W      = 16;
    localparam int SET_OUT_W   = 4;
    localparam int WAY_OUT_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int OFFSET_W    = 4;
    localparam int SETBITS_W   = 3;

    // Default geometry
    localparam int DEFAULT_WAYS = 4;
    localparam int DEFAULT_SETS = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_POLICY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS       = 2'd2;

    // Replacement policy codes
    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    // Reset values of the configuration registers
    localparam logic [OFFSET_W-1:0]  RESET_OFFSET_BITS = 4'd2;
    localparam logic [SETBITS_W-1:0] RESET_SET_BITS    = 3'd4;

    // One access
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_write;
    } sacache_req_t;

    // One lookup result
    typedef struct packed {
        logic                 hit;
        logic [SET_OUT_W-1:0] set_number;
        logic [WAY_OUT_W-1:0] way_number;
        logic                 filled_empty;
        logic                 replaced_valid;
    } sacache_resp_t;

    // Outcome of a set lookup
    typedef struct packed {
        logic hit;
        logic filled;
        logic replaced;
    } sacache_outcome_t;

endpackage

`default_nettype wire

[src/sacache_lookup.sv]
// Set lookup: tag compare, fill/victim choice and next contents of one set row.
`default_nettype none

module sacache_lookup #(
    parameter int WAYS  = sacache_pkg::DEFAULT_WAYS,
    parameter int TAG_W = sacache_pkg::ADDR_W,
    parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  wire logic                             policy,
    input  wire logic                             is_write,
    input  wire logic [TAG_W-1:0]                 tag,
    input  wire logic [WAYS-1:0]                  valid_row,
    input  wire logic [WAYS-1:0]                  dirty_row,
    input  wire logic [WAYS-1:0][TAG_W-1:0]       tag_row,
    input  wire logic [WAYS-1:0][WAY_W-1:0]       rank_row,
    output sacache_pkg::sacache_outcome_t         outcome,
    output logic      [WAY_W-1:0]                 way,
    output logic      [WAYS-1:0]                  valid_next,
    output logic      [WAYS-1:0]                  dirty_next,
    output logic      [WAYS-1:0][TAG_W-1:0]       tag_next,
    output logic      [WAYS-1:0][WAY_W-1:0]       rank_next
);

    localparam int CNT_W = $clog2(WAYS + 1);

    logic [WAYS-1:0]  match;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             any_empty;
    logic [WAY_W-1:0] empty_way;
    logic [WAY_W-1:0] oldest_way;
    logic [CNT_W-1:0] valid_cnt;
    logic             promote;
    logic             was_valid;
    logic [WAY_W-1:0] old_rank;

    // Compare all ways in parallel; pick the first match, first empty way and oldest line
    always_comb
    begin
        hit        = 1'b0;
        hit_way    = '0;
        any_empty  = 1'b0;
        empty_way  = '0;
        oldest_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            match[w] = valid_row[w] && (tag_row[w] == tag);
            if (match[w])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid_row[w])
            begin
                any_empty = 1'b1;
                empty_way = WAY_W'(w);
            end
            // with every way valid the ranks form a permutation, so rank zero is the oldest
            if (rank_row[w] == '0)
            begin
                oldest_way = WAY_W'(w);
            end
        end
    end

    // Count the valid lines of the set
    always_comb
    begin
        valid_cnt = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            valid_cnt = valid_cnt + CNT_W'(valid_row[w]);
        end
    end

    // Choose the way and report the outcome
    always_comb
    begin
        outcome.hit      = hit;
        outcome.filled   = !hit && any_empty;
        outcome.replaced = !hit && !any_empty;
        if (hit)
        begin
            way = hit_way;
        end
        else if (any_empty)
        begin
            way = empty_way;
        end
        else
        begin
            way = oldest_way;
        end
    end

    assign promote   = !hit || (policy == sacache_pkg::POLICY_LRU);
    assign was_valid = valid_row[way];
    assign old_rank  = rank_row[way];

    // Build the next row: promote the chosen line (not on a FIFO hit), age the younger ones, fill on a miss
    always_comb
    begin
        valid_next = valid_row;
        dirty_next = dirty_row;
        tag_next   = tag_row;
        for (int v = 0; v < WAYS; v++)
        begin
            rank_next[v] = rank_row[v];
            if (promote && (WAY_W'(v) != way) && was_valid && valid_row[v]
                && (rank_row[v] > old_rank))
            begin
                rank_next[v] = rank_row[v] - WAY_W'(1);
            end
        end
        if (promote)
        begin
            if (was_valid)
            begin
                rank_next[way] = WAY_W'(valid_cnt - CNT_W'(1));
            end
            else
            begin
                rank_next[way] = WAY_W'(valid_cnt);
            end
        end
        valid_next[way] = 1'b1;
        if (hit)
        begin
            dirty_next[way] = dirty_row[way] | is_write;
        end
        else
        begin
            dirty_next[way] = is_write;
            tag_next[way]   = tag;
        end
    end

endmodule

`default_nettype wire

[src/set_assoc_cache_lru_fifo_unit.sv]
// Top level of the set-associative cache tag and replacement unit.
//
// Usage:
//   Access channel: raise start with an access on request; it is taken at
//   any clock edge where start is high and busy is low. busy stays low, so
//   one access may be issued every cycle.
//   Result channel: done pulses for one cycle with the lookup result on
//   result; done and result are registered from the access register, which
//   holds the taken access during its lookup. Results come back in
//   issue order, one per access. The receiver cannot stall and must take the
//   result in the cycle that done is high.
//   Configuration channel: cfg_ready is always high; a transaction writes
//   cfg_data to register cfg_index (0 policy, 1 offset bits, 2 set bits;
//   other indexes are ignored). Write only while no access is in flight.
//   Throughput is one access per cycle: the set row is read and compared in all
//   ways straight from the access register, and written back with the result,
//   so back-to-back accesses to the same set see each other's updates.
//   Reset clears all valid, dirty and age state at once (no clearing pass),
//   loads the register defaults (LRU, offset 2, set bits 4) and drops any
//   access in flight.
`default_nettype none

module set_assoc_cache_lru_fifo_unit #(
    parameter int WAYS = sacache_pkg::DEFAULT_WAYS,
    parameter int SETS = sacache_pkg::DEFAULT_SETS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire sacache_pkg::sacache_req_t              request,
    output logic                                        done,
    output sacache_pkg::sacache_resp_t                  result,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [sacache_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sacache_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TAG_W  = sacache_pkg::ADDR_W;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int MSET_W = 7;   // set_bits up to 7 selects up to 7 index bits
    localparam int FOLD_W = 18;  // holds SETS shifted left by up to 6

    // Configuration registers
    logic                               policy_reg;
    logic [sacache_pkg::OFFSET_W-1:0]   offset_bits_reg;
    logic [sacache_pkg::SETBITS_W-1:0]  set_bits_reg;

    // Access register
    logic                               pend_reg;
    sacache_pkg::sacache_req_t          req_reg;

    // Set rows
    logic [WAYS-1:0]                    valid_reg [SETS];
    logic [WAYS-1:0]                    dirty_reg [SETS];
    logic [WAYS-1:0][WAY_W-1:0]         rank_reg  [SETS];
    logic [WAYS-1:0][TAG_W-1:0]         tag_reg   [SETS];

    // Result register
    logic                               done_reg;
    sacache_pkg::sacache_resp_t         result_reg;
    sacache_pkg::sacache_resp_t         result_next;

    // Lookup signals
    logic [TAG_W-1:0]                   blk;
    logic [MSET_W-1:0]                  set_mask;
    logic [MSET_W-1:0]                  set_raw;
    logic [SET_W-1:0]                   set_idx;
    logic [TAG_W-1:0]                   tag;
    sacache_pkg::sacache_outcome_t      outcome;
    logic [WAY_W-1:0]                   way;
    logic [WAYS-1:0]                    valid_next;
    logic [WAYS-1:0]                    dirty_next;
    logic [WAYS-1:0][TAG_W-1:0]         tag_next;
    logic [WAYS-1:0][WAY_W-1:0]         rank_next;

    // Reduce a narrow set index modulo SETS by conditional subtraction
    function automatic logic [SET_W-1:0] fold_set(input logic [MSET_W-1:0] v);
        logic [FOLD_W-1:0] rem;
        rem = FOLD_W'(v);
        for (int k = MSET_W - 1; k >= 0; k--)
        begin
            if (rem >= (FOLD_W'(SETS) << k))
            begin
                rem = rem - (FOLD_W'(SETS) << k);
            end
        end
        return SET_W'(rem);
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= sacache_pkg::POLICY_LRU;
            offset_bits_reg <= sacache_pkg::RESET_OFFSET_BITS;
            set_bits_reg    <= sacache_pkg::RESET_SET_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sacache_pkg::CFG_REPLACE_POLICY: policy_reg      <= cfg_data[0];
                sacache_pkg::CFG_OFFSET_BITS:    offset_bits_reg <= cfg_data;
                sacache_pkg::CFG_SET_BITS:
                    set_bits_reg <= cfg_data[sacache_pkg::SETBITS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Capture an access transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
    end

    // Split the address into set and tag under the current configuration
    assign blk      = req_reg.address >> offset_bits_reg;
    assign set_mask = MSET_W'((8'd1 << set_bits_reg) - 8'd1);
    assign set_raw  = blk[MSET_W-1:0] & set_mask;
    assign set_idx  = fold_set(set_raw);
    assign tag      = blk >> set_bits_reg;

    sacache_lookup #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .WAY_W (WAY_W)
    ) u_lookup (
        .policy     (policy_reg),
        .is_write   (req_reg.is_write),
        .tag        (tag),
        .valid_row  (valid_reg[set_idx]),
        .dirty_row  (dirty_reg[set_idx]),
        .tag_row    (tag_reg[set_idx]),
        .rank_row   (rank_reg[set_idx]),
        .outcome    (outcome),
        .way        (way),
        .valid_next (valid_next),
        .dirty_next (dirty_next),
        .tag_next   (tag_next),
        .rank_next  (rank_next)
    );

    // Write back the set row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
                dirty_reg[s] <= '0;
                rank_reg[s]  <= '0;
            end
        end
        else if (pend_reg)
        begin
            valid_reg[set_idx] <= valid_next;
            dirty_reg[set_idx] <= dirty_next;
            rank_reg[set_idx]  <= rank_next;
        end
    end

    // Write back tags; no reset since a tag is only compared once its line is valid
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            tag_reg[set_idx] <= tag_next;
        end
    end

    // Form the result
    always_comb
    begin
        result_next.hit            = outcome.hit;
        result_next.set_number     = sacache_pkg::SET_OUT_W'(set_idx);
        result_next.way_number     = sacache_pkg::WAY_OUT_W'(way);
        result_next.filled_empty   = outcome.filled;
        result_next.replaced_valid = outcome.replaced;
    end

    // Register the done strobe and the result together; the result holds until the next access
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
